// ===== rtl/multiplexed_seven_segment_scan_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scan core
// Shared forms for clocked implications, gated by the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH

// Same-cycle implication.
`define MSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan core check failed in the same cycle");

// Next-cycle implication.
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan core check failed one cycle later");

`endif

// ===== rtl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan package
// Sizes, constants, the segment table and the types shared by the scan core.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int POS_W       = 8;
  localparam int SEG_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int WORD_BITS   = POS_W + SEG_W;
  localparam int BIT_CNT_W   = $clog2(WORD_BITS);

  localparam logic [POS_W-1:0]   LEFT_POS    = POS_W'(1 << (DIGIT_COUNT - 1));
  localparam logic [VALUE_W-1:0] RESET_VALUE = VALUE_W'(128);

  // Division by ten as a multiply by the scaled reciprocal; exact for all
  // 32-bit dividends.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 PROD_W      = 2 * VALUE_W;
  localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [SEG_W-1:0] segments;
  } seg_word_t;

  typedef struct packed {
    logic              stage_valid;
  } front_status_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
  } queue_status_t;

  // Active-low segment code for one decimal digit.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'd0:    code = 8'b1100_0000;
      4'd1:    code = 8'b1111_1001;
      4'd2:    code = 8'b1010_0100;
      4'd3:    code = 8'b1011_0000;
      4'd4:    code = 8'b1001_1001;
      4'd5:    code = 8'b1001_0010;
      4'd6:    code = 8'b1000_0010;
      4'd7:    code = 8'b1111_1000;
      4'd8:    code = 8'b1000_0000;
      4'd9:    code = 8'b1001_1000;
      default: code = 8'b1111_1111;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/mss_front.sv =====
// ----------------------------------------------------------------------------
// Scan front end
// Takes scan ticks, tracks the digit position and the remainder, splits off
// the low decimal digit and forms the 16-bit display word.
// ----------------------------------------------------------------------------
module mss_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [mss_pkg::VALUE_W-1:0]  display_value,
  input  logic                         q_full,
  output logic                         wr_en,
  output mss_pkg::seg_word_t           wr_word,
  output mss_pkg::front_status_t       status
);
  import mss_pkg::*;

  logic [POS_W-1:0]   digit_select;
  logic [VALUE_W-1:0] remaining_value;
  logic [POS_W-1:0]   pos_now;
  logic [VALUE_W-1:0] src_value;
  logic [PROD_W-1:0]  product;
  logic [QUOT_W-1:0]  quot;
  logic               accept;
  logic               advance;

  // Stage register: enough of dividend and quotient to rebuild the digit.
  logic               stage_valid;
  logic [3:0]         stage_v_low;
  logic [2:0]         stage_q_low;
  logic [POS_W-1:0]   stage_pos;
  logic [3:0]         digit;

  assign advance = stage_valid && !q_full;
  assign full    = stage_valid && q_full;
  assign accept  = push && !full;

  // A zero position starts a new pass and latches the incoming value.
  always_comb begin
    if (digit_select == '0) begin
      pos_now   = LEFT_POS;
      src_value = display_value;
    end else begin
      pos_now   = digit_select;
      src_value = remaining_value;
    end
  end

  assign product = PROD_W'(src_value) * PROD_W'(RECIP_TEN);
  assign quot    = product[PROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= 1'b0;
      digit_select    <= LEFT_POS;
      remaining_value <= RESET_VALUE;
    end else begin
      if (accept) begin
        stage_valid     <= 1'b1;
        digit_select    <= pos_now >> 1;
        remaining_value <= VALUE_W'(quot);
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_v_low <= src_value[3:0];
      stage_q_low <= quot[2:0];
      stage_pos   <= pos_now;
    end
  end

  // Remainder mod 16 is enough: v - 10*q is already below ten.
  assign digit = stage_v_low - ({stage_q_low[0], 3'b000} + {stage_q_low, 1'b0});

  assign wr_en            = advance;
  assign wr_word.position = stage_pos;
  assign wr_word.segments = seg_code(digit);
  assign status.stage_valid = stage_valid;

endmodule

// ===== rtl/mss_queue.sv =====
// ----------------------------------------------------------------------------
// Word queue
// Two-entry FIFO of display words between the front end and the serializer.
// ----------------------------------------------------------------------------
module mss_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  mss_pkg::seg_word_t     wr_word,
  output logic                   q_full,
  output logic                   q_valid,
  input  logic                   rd_en,
  output mss_pkg::seg_word_t     rd_word,
  output mss_pkg::queue_status_t status
);
  import mss_pkg::*;

  seg_word_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] level;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (level == QCNT_W'(QDEPTH));
  assign q_valid = (level != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_word = entries[rd_ptr];
  assign status.level = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_word;
    end
  end

endmodule

// ===== rtl/mss_back.sv =====
// ----------------------------------------------------------------------------
// Serializer
// Shifts each display word out MSB first and marks its last bit as the latch.
// ----------------------------------------------------------------------------
module mss_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mss_pkg::seg_word_t rd_word,
  output logic               rd_en,
  output logic               empty,
  input  logic               pop,
  output logic               serial_bit,
  output logic               latch_strobe
);
  import mss_pkg::*;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_BITS - 1);

  logic                 busy;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [WORD_BITS-1:0] shreg;
  logic                 last;
  logic                 take;
  logic                 load;

  assign last = (bit_cnt == LAST_BIT);
  assign take = pop && busy;
  // Reload right behind the last bit so words leave without a gap.
  assign load = q_valid && (!busy || (take && last));

  assign rd_en        = load;
  assign empty        = !busy;
  assign serial_bit   = shreg[WORD_BITS-1];
  assign latch_strobe = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      if (load) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (take) begin
        if (last) begin
          busy    <= 1'b0;
          bit_cnt <= '0;
        end else begin
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= rd_word;
    end else if (take) begin
      shreg <= shreg << 1;
    end
  end

endmodule

// ===== rtl/multiplexed_seven_segment_scan_core.sv =====
// ----------------------------------------------------------------------------
// Multiplexed seven-segment scan core
// One scan tick in, sixteen serial bits out, refreshing one digit position.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake     Payload
// tick      in         push / full   display_value[31:0]
// bit       out        empty / pop   serial_bit, latch_strobe
//
// Each accepted tick yields sixteen output transactions, one bit per cycle
// while pop is held; the serializer, which moves one bit per transaction,
// sets the sustained tick rate. The front end holds an accepted tick in its
// stage register and writes its display word into the queue once the queue
// has room; the word then moves to the serializer's shift register. The next
// tick can be taken in the following cycle while the two-entry word queue
// has room.
// Reset is synchronous: the position returns to the leftmost digit and the
// remainder to 128, and the word queue is emptied. Either side may stall at will.
// ----------------------------------------------------------------------------
`include "multiplexed_seven_segment_scan_core_macros.svh"

module multiplexed_seven_segment_scan_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [mss_pkg::VALUE_W-1:0] display_value,
  output logic                        empty,
  input  logic                        pop,
  output logic                        serial_bit,
  output logic                        latch_strobe
);
  import mss_pkg::*;

  // Front end to queue: one display word per cycle at most.
  logic          wr_en;
  seg_word_t     wr_word;
  logic          q_full;

  // Queue to serializer.
  logic          q_valid;
  logic          rd_en;
  seg_word_t     rd_word;

  front_status_t front_stat;
  queue_status_t queue_stat;

  // The front end owns the position register, the remainder and the divide
  // by ten; it stalls only when its stage register cannot drain.
  mss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .display_value (display_value),
    .q_full        (q_full),
    .wr_en         (wr_en),
    .wr_word       (wr_word),
    .status        (front_stat)
  );

  // The queue decouples word generation from the slow bit stream.
  mss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_word (wr_word),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_en   (rd_en),
    .rd_word (rd_word),
    .status  (queue_stat)
  );

  // The serializer presents one bit per output transaction and raises the
  // latch strobe on the sixteenth bit of each word.
  mss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .rd_word      (rd_word),
    .rd_en        (rd_en),
    .empty        (empty),
    .pop          (pop),
    .serial_bit   (serial_bit),
    .latch_strobe (latch_strobe)
  );

  // The input side only pushes back when the queue is completely full.
  `MSS_ASSERT_NOW(a_full_means_queue_full, clk, rst, full, queue_stat.level == QCNT_W'(QDEPTH))

  // An accepted tick always occupies the front stage in the next cycle.
  `MSS_ASSERT_NEXT(a_accept_fills_stage, clk, rst, push && !full, front_stat.stage_valid)

  // A word is never cut short: after any bit but the last, more bits follow.
  `MSS_ASSERT_NEXT(a_word_not_cut, clk, rst, pop && !empty && !latch_strobe, !empty)

  // A word leaves the queue only when the serializer has room for it.
  `MSS_ASSERT_NOW(a_load_when_free, clk, rst, rd_en && !empty, pop && latch_strobe)

endmodule

// ===== tb/sv/tb_multiplexed_seven_segment_scan_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment scan core testbench
// Drives scan ticks through the push/full side and checks every serial bit
// and latch strobe that leaves through the empty/pop side. The expected bits
// come from a scan predictor inside this file, which tracks the digit
// position and the latched remainder. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_scan_core;

  import mss_pkg::*;

  // One output transaction: a data bit for the shift-register chain and the
  // strobe that marks the last bit of a display word.
  typedef struct packed {
    logic serial_bit;
    logic latch_strobe;
  } scan_bit_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               push          = 1'b0;
  logic               full;
  logic [VALUE_W-1:0] display_value = '0;
  logic               empty;
  logic               pop           = 1'b0;
  logic               serial_bit;
  logic               latch_strobe;

  // Active-low segment patterns for the digits 0 to 9.
  logic [SEG_W-1:0] digit_segments [0:9] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  // Scan predictor state. It mirrors the position register and the latched
  // remainder of the block, starting from their reset values.
  logic [POS_W-1:0]   scan_position  = LEFT_POS;
  logic [VALUE_W-1:0] scan_remainder = RESET_VALUE;

  // Bits still owed by the block, oldest first.
  scan_bit_t pending_bits [$];

  int mismatch_count = 0;
  int bits_checked   = 0;

  // Idling controls shared by the test tasks and the two handshake sides.
  // When a flag is low that side runs with no gaps at all. rx_hold_cycles is
  // a one-off long hold-off of the receiver, counted down by the receiver.
  bit tx_idle        = 1'b1;
  bit rx_idle        = 1'b1;
  int rx_hold_cycles = 0;

  multiplexed_seven_segment_scan_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .display_value(display_value),
    .empty        (empty),
    .pop          (pop),
    .serial_bit   (serial_bit),
    .latch_strobe (latch_strobe)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Safety net against a hung handshake. The slowest legal run is well under
  // a quarter of this.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Works out the sixteen bits that one accepted tick causes. A zero position
  // marks the start of a scan pass: the position reloads to the leftmost digit
  // and the tick's value is latched. Every other tick keeps working on the
  // remainder that is already held, so its value has no effect.
  function automatic void predict_scan_word(input logic [VALUE_W-1:0] value);
    logic [3:0]           digit;
    logic [WORD_BITS-1:0] word;
    if (scan_position == '0) begin
      scan_position  = LEFT_POS;
      scan_remainder = value;
    end
    digit          = 4'(scan_remainder % 10);
    scan_remainder = scan_remainder / 10;
    word           = {scan_position, digit_segments[digit]};
    // The word leaves MSB first; the strobe rides on the final bit.
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      pending_bits.push_back('{word[k], k == 0});
    end
    scan_position = scan_position >> 1;
  endfunction

  // Offers one tick and returns at the clock edge that accepts it. Push is
  // only lowered when a gap is drawn, so back-to-back ticks keep it high.
  // While push is low the value lines carry noise.
  task automatic send_tick(input logic [VALUE_W-1:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push          <= 1'b0;
      display_value <= $urandom;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    display_value <= value;
    do @(posedge clk); while (full);
    predict_scan_word(value);
  endtask

  // One whole scan pass: the first tick carries the value that gets latched,
  // the other seven carry noise that the block must ignore.
  task automatic send_pass(input logic [VALUE_W-1:0] value);
    send_tick(value);
    repeat (DIGIT_COUNT - 1) send_tick($urandom);
  endtask

  task automatic stop_sender();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bits.size() != 0) @(posedge clk);
  endtask

  // Receiver. Pop changes at the falling edge and the transaction is judged at
  // the rising edge, before the block updates its outputs. Each accepted bit
  // draws the number of cycles to wait before the next pop.
  initial begin : bit_receiver
    int        wait_cycles;
    scan_bit_t want;
    wait_cycles = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        rx_hold_cycles--;
      end else if (wait_cycles > 0) begin
        pop <= 1'b0;
        wait_cycles--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_bits.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transaction: serial_bit %b latch_strobe %b",
                     serial_bit, latch_strobe);
        end else begin
          want = pending_bits.pop_front();
          if (serial_bit !== want.serial_bit || latch_strobe !== want.latch_strobe) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("transaction %0d: serial_bit exp %b got %b, latch_strobe exp %b got %b",
                       bits_checked, want.serial_bit, serial_bit,
                       want.latch_strobe, latch_strobe);
          end
        end
        bits_checked++;
        wait_cycles = rx_idle ? $urandom_range(0, 14) : 0;
      end
    end
  end

  // Right after reset the block scans the reset remainder of 128 before it
  // ever latches a value, so the first pass shows 8, 2, 1 and then zeros no
  // matter what the ticks carry. Extremes are offered here to prove it.
  task automatic test_reset_pass();
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    repeat (DIGIT_COUNT - 2) send_tick($urandom);
  endtask

  // The largest value has ten decimal digits; only the low eight appear and
  // the top two are dropped at the next reload.
  task automatic test_extreme_values();
    send_pass(32'hFFFF_FFFF);
  endtask

  // A single digit runs the remainder to zero after the first position, and
  // the leading positions then show zeros.
  task automatic test_exhausted_remainder();
    send_pass(32'd3);
  endtask

  // The receiver stops for a long stretch while ticks keep coming at full
  // rate, so the word queue fills and full must hold the sender off.
  task automatic test_full_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 300;
    send_pass($urandom);
    send_pass($urandom_range(0, 99_999_999));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // The sender goes quiet until every owed bit has left, then resumes with a
  // fresh pass, so the block restarts from a fully idle state.
  task automatic test_drain_pause();
    stop_sender();
    wait_drained();
    send_pass($urandom);
  endtask

  // Whole scan passes with the latched value drawn from several shapes: any
  // 32-bit value, values that fit in eight digits, short values that leave
  // leading zeros, powers of ten and their neighbors, and the two extremes.
  // Each pass also picks whether either side idles.
  task automatic test_random_values();
    logic [VALUE_W-1:0] value;
    for (int pass = 0; pass < 52; pass++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0, 1: value = $urandom;
        2:    value = $urandom_range(0, 99_999_999);
        3:    value = $urandom_range(0, 999);
        4: begin
          value = 1;
          repeat ($urandom_range(0, 9)) value = value * 10;
          value = value - $urandom_range(0, 1);
        end
        default: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      endcase
      send_pass(value);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_pass();
    test_extreme_values();
    test_exhausted_remainder();
    test_full_backpressure();
    test_drain_pause();
    test_random_values();

    // Let the last words drain, then give the block time to show any stray
    // transaction that it should not produce.
    stop_sender();
    wait_drained();
    repeat (32) @(posedge clk);

    if (mismatch_count == 0 && pending_bits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_front.sv
rtl/mss_queue.sv
rtl/mss_back.sv
rtl/multiplexed_seven_segment_scan_core.sv
tb/sv/tb_multiplexed_seven_segment_scan_core.sv
